// ===== rtl/mrsd_pkg.sv =====
`timescale 1ns / 1ps

package mrsd_pkg;

	// status nibbles of the channel voice messages and of system messages
	localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
	localparam logic [3:0] TYPE_CTRL       = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
	localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
	localparam logic [3:0] TYPE_SYSTEM     = 4'hF;

	localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
	localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

	localparam logic [3:0] DRUM_CHANNEL_RESET = 4'd9;

	localparam logic [1:0] EV_NOTE_ON   = 2'd0;
	localparam logic [1:0] EV_NOTE_OFF  = 2'd1;
	localparam logic [1:0] EV_DRUM_ON   = 2'd2;
	localparam logic [1:0] EV_ALL_OFF   = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [3:0] channel;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [6:0] program_res;
	} mrsd_event_t;

endpackage

// ===== rtl/mrsd_parser.sv =====
`timescale 1ns / 1ps

module mrsd_parser import mrsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  midi_byte,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	output mrsd_event_t ev
);

	logic [7:0] status_q;
	logic       count_q;
	logic       two_q;
	logic [6:0] first_q;
	logic [3:0] drum_q;
	logic [6:0] program_q [16];

	logic       is_rt;
	logic       is_sys;
	logic       has_status;
	logic       take_first;
	logic       complete;
	logic       is_drum;
	logic [3:0] typ;
	logic [3:0] ch;
	logic [6:0] d1;
	logic [6:0] d2;

	assign is_rt      = &midi_byte[7:3];
	assign is_sys     = midi_byte[7:4] == TYPE_SYSTEM;
	assign has_status = status_q != 8'h00;
	assign take_first = two_q && !count_q;
	assign typ        = status_q[7:4];
	assign ch         = status_q[3:0];
	assign is_drum    = ch == drum_q;
	assign d1         = two_q ? first_q : midi_byte[6:0];
	assign d2         = two_q ? midi_byte[6:0] : 7'd0;
	assign complete   = fire && !midi_byte[7] && has_status && !take_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 8'h00;
			count_q  <= 1'b0;
			two_q    <= 1'b0;
			first_q  <= 7'd0;
			drum_q   <= DRUM_CHANNEL_RESET;
			for (int i = 0; i < 16; i++) begin
				program_q[i] <= 7'd0;
			end
		end else begin
			if (cfg_wr_en) begin
				drum_q <= cfg_wr_data;
			end
			if (fire) begin
				if (midi_byte[7]) begin
					// real-time bytes leave everything alone
					if (!is_rt) begin
						count_q <= 1'b0;
						if (is_sys) begin
							status_q <= 8'h00;
						end else begin
							status_q <= midi_byte;
							two_q    <= !(midi_byte[7:4] == TYPE_PROGRAM ||
								midi_byte[7:4] == TYPE_CHAN_PRESS);
						end
					end
				end else if (has_status) begin
					if (take_first) begin
						first_q <= midi_byte[6:0];
						count_q <= 1'b1;
					end else begin
						count_q <= 1'b0;
						if (typ == TYPE_PROGRAM) begin
							program_q[ch] <= d1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		ev             = '0;
		ev.channel     = ch;
		if (complete) begin
			case (typ)
				TYPE_NOTE_ON: begin
					ev.note = d1;
					if (d2 != 7'd0) begin
						ev.valid    = 1'b1;
						ev.velocity = d2;
						if (is_drum) begin
							ev.kind = EV_DRUM_ON;
						end else begin
							ev.kind        = EV_NOTE_ON;
							ev.program_res = program_q[ch];
						end
					end else begin
						// velocity zero is a note-off, dropped on the drum channel
						ev.valid = !is_drum;
						ev.kind  = EV_NOTE_OFF;
					end
				end
				TYPE_NOTE_OFF: begin
					ev.note  = d1;
					ev.valid = !is_drum;
					ev.kind  = EV_NOTE_OFF;
				end
				TYPE_CTRL: begin
					ev.valid = d1 == CC_ALL_SOUND_OFF || d1 == CC_ALL_NOTES_OFF;
					ev.kind  = EV_ALL_OFF;
				end
				default: begin
					ev.valid = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/midi_running_status_dispatcher.sv =====
`timescale 1ns / 1ps

// channel   dir  width  beat contents
// s_*       in   8      one raw midi byte
// m_*       out  32     one event: kind, channel, note, velocity, program
// cfg_*     in   4      drum channel, written when cfg_wr_en is high
//
// one byte accepted per cycle while s_tready is high; an event is offered from the event
// register after its last byte has passed the byte register; the two registers form a
// two-stage pipe, the byte stage advances whenever the event register is empty or being taken
// reset clears the running status, the program table and sets drum channel 9
// m_tready low with an event waiting stalls both stages, s_tready drops once
// the byte stage is also full

module midi_running_status_dispatcher import mrsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] midi_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] event_kind, [5:2] channel, [12:6] note, [19:13] velocity,
	// [26:20] program_res, [31:27] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	mrsd_event_t out_q;
	mrsd_event_t ev;
	logic        advance;
	logic        fire;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	mrsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.midi_byte   (byte_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ev          (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= ev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (ev.valid) begin
			out_q <= ev;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.program_res, out_q.velocity, out_q.note,
		out_q.channel, out_q.kind};

`ifndef ASSERT_OFF
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("byte stage changed while stalled");

	a_off_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == EV_NOTE_OFF |->
		out_q.velocity == 7'd0 && out_q.program_res == 7'd0)
		else $error("note-off carries velocity or program");

	a_all_off_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == EV_ALL_OFF |->
		out_q.note == 7'd0 && out_q.velocity == 7'd0 && out_q.program_res == 7'd0)
		else $error("all-off carries data");

	a_on_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == EV_NOTE_ON || out_q.kind == EV_DRUM_ON) |->
		out_q.velocity != 7'd0)
		else $error("note-on with zero velocity");

	a_drum_program: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == EV_DRUM_ON |-> out_q.program_res == 7'd0)
		else $error("drum note-on carries program");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import mrsd_pkg::*;

	localparam logic [3:0] TYPE_KEY_PRESS  = 4'hA;
	localparam logic [3:0] TYPE_PITCH_BEND = 4'hE;
	localparam logic [7:0] REALTIME_FIRST  = 8'hF8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] channel;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [6:0] program_res;
	} midi_event_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] midi_byte
	logic        m_tvalid;
	logic        m_tready;
	// [1:0] event_kind, [5:2] channel, [12:6] note, [19:13] velocity,
	// [26:20] program_res, [31:27] zero
	logic [31:0] m_tdata;
	logic        cfg_wr_en;
	logic [3:0]  cfg_wr_data;

	// parser state as the block should hold it
	logic [7:0] run_status;
	logic [1:0] data_cnt;
	logic [1:0] data_need;
	logic [6:0] first_byte;
	logic [6:0] programs [16];
	logic [3:0] drum_ch;

	midi_event_t expected_events[$];
	int bytes_sent = 0;
	int events_checked = 0;
	int mismatches = 0;
	int kind_seen [4] = '{0, 0, 0, 0};
	int cycles = 0;
	bit tx_quiet;
	bit rx_quiet;
	int rx_hold_req;

	midi_running_status_dispatcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void reset_parser_state();
		run_status = '0;
		data_cnt = '0;
		data_need = '0;
		first_byte = '0;
		drum_ch = DRUM_CHANNEL_RESET;
		for (int i = 0; i < 16; i++)
			programs[i] = '0;
	endfunction

	// returns 1 when the byte completes a message that produces an event
	function automatic bit decode_midi_byte(input logic [7:0] b, output midi_event_t ev);
		logic [6:0] d1;
		logic [6:0] d2;
		logic [3:0] ch;
		bit two;
		ev = '0;
		if (b[7]) begin
			if (b >= REALTIME_FIRST)
				return 1'b0;
			if (b[7:4] == TYPE_SYSTEM) begin
				run_status = '0;
				data_cnt = '0;
				return 1'b0;
			end
			run_status = b;
			data_cnt = '0;
			data_need = (b[7:4] == TYPE_PROGRAM || b[7:4] == TYPE_CHAN_PRESS) ? 2'd1 : 2'd2;
			return 1'b0;
		end
		if (run_status == '0)
			return 1'b0;
		if (data_need == 2'd2 && data_cnt == '0) begin
			first_byte = b[6:0];
			data_cnt = 2'd1;
			return 1'b0;
		end
		// a one-byte message, or the second byte of a two-byte one, completes on this byte
		two = (data_need == 2'd2);
		d1 = two ? first_byte : b[6:0];
		d2 = two ? b[6:0] : 7'd0;
		ch = run_status[3:0];
		data_cnt = '0;
		ev.channel = ch;
		case (run_status[7:4])
			TYPE_NOTE_ON, TYPE_NOTE_OFF: begin
				if (run_status[7:4] == TYPE_NOTE_ON && d2 != 7'd0) begin
					ev.note = d1;
					ev.velocity = d2;
					if (ch == drum_ch) begin
						ev.kind = EV_DRUM_ON;
					end else begin
						ev.kind = EV_NOTE_ON;
						ev.program_res = programs[ch];
					end
					return 1'b1;
				end
				if (ch == drum_ch)
					return 1'b0;
				ev.kind = EV_NOTE_OFF;
				ev.note = d1;
				return 1'b1;
			end
			TYPE_CTRL: begin
				if (d1 == CC_ALL_SOUND_OFF || d1 == CC_ALL_NOTES_OFF) begin
					ev.kind = EV_ALL_OFF;
					return 1'b1;
				end
			end
			TYPE_PROGRAM: begin
				programs[ch] = d1;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void note_mismatch(input string what, input midi_event_t want,
			input midi_event_t got, input logic [4:0] pad);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] %s: expected kind %0d ch %0d note %0d vel %0d prog %0d, got kind %0d ch %0d note %0d vel %0d prog %0d pad %0h",
				$time, what, want.kind, want.channel, want.note, want.velocity,
				want.program_res, got.kind, got.channel, got.note, got.velocity,
				got.program_res, pad);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		midi_event_t ev;
		@(negedge clk);
		if (!tx_quiet && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		if (decode_midi_byte(b, ev))
			expected_events.push_back(ev);
	endtask

	// a byte may complete silently, so the pipe is also given time to settle past the last event
	task automatic drain_pipeline();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_drum_channel(input logic [3:0] ch);
		drain_pipeline();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ch;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		drum_ch = ch;
	endtask

	// mostly well-formed messages, some with running status, plus noise and cut-off ones
	task automatic send_random_message(inout logic [7:0] last_status);
		logic [7:0] msg[$];
		logic [3:0] kind_nib;
		logic [3:0] ch;
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			msg.push_back(8'($urandom_range(255)));
			last_status = '0;
		end else if (pick < 14) begin
			msg.push_back({TYPE_SYSTEM, 4'($urandom_range(7))});
			last_status = '0;
		end else begin
			pick = $urandom_range(99);
			if (pick < 35)
				kind_nib = TYPE_NOTE_ON;
			else if (pick < 55)
				kind_nib = TYPE_NOTE_OFF;
			else if (pick < 70)
				kind_nib = TYPE_CTRL;
			else if (pick < 80)
				kind_nib = TYPE_PROGRAM;
			else if (pick < 87)
				kind_nib = TYPE_CHAN_PRESS;
			else if (pick < 93)
				kind_nib = TYPE_KEY_PRESS;
			else
				kind_nib = TYPE_PITCH_BEND;
			ch = ($urandom_range(3) == 0) ? drum_ch : 4'($urandom_range(15));
			if ({kind_nib, ch} != last_status || $urandom_range(2) == 0)
				msg.push_back({kind_nib, ch});
			last_status = {kind_nib, ch};
			if (kind_nib == TYPE_CTRL && $urandom_range(2) == 0)
				msg.push_back({1'b0, ($urandom_range(1) != 0) ? CC_ALL_SOUND_OFF : CC_ALL_NOTES_OFF});
			else
				msg.push_back(8'($urandom_range(127)));
			if (kind_nib != TYPE_PROGRAM && kind_nib != TYPE_CHAN_PRESS)
				msg.push_back(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(127)));
			if ($urandom_range(9) == 0)
				msg.insert($urandom_range(msg.size()), 8'($urandom_range(255, REALTIME_FIRST)));
			if ($urandom_range(19) == 0) begin
				void'(msg.pop_back());
				last_status = '0;
			end
		end
		foreach (msg[i])
			send_byte(msg[i]);
	endtask

	task automatic test_note_events();
		send_byte(8'h00);                   // data with no status
		send_byte({TYPE_NOTE_ON, 4'd15});
		send_byte(8'h00);
		send_byte(8'hFE);                   // real-time inside a message
		send_byte(8'h7F);
		send_byte(8'h7F);                   // running status, zero velocity
		send_byte(8'h00);
		drain_pipeline();
	endtask

	task automatic test_program_table();
		send_byte({TYPE_PROGRAM, 4'd3});
		send_byte(8'h7F);
		send_byte({TYPE_NOTE_ON, 4'd3});
		send_byte(8'h45);
		send_byte(8'h01);
		drain_pipeline();
	endtask

	task automatic test_drum_notes();
		send_byte({TYPE_NOTE_ON, DRUM_CHANNEL_RESET});
		send_byte(8'h24);
		send_byte(8'h7F);
		send_byte(8'h24);
		send_byte(8'h00);
		drain_pipeline();
	endtask

	task automatic test_all_off_controls();
		send_byte({TYPE_CTRL, 4'd5});
		send_byte({1'b0, CC_ALL_SOUND_OFF});
		send_byte(8'h00);
		send_byte({1'b0, CC_ALL_NOTES_OFF});
		send_byte(8'h7F);
		send_byte(8'h07);
		send_byte(8'h64);
		drain_pipeline();
	endtask

	task automatic test_silent_messages();
		send_byte({TYPE_CHAN_PRESS, 4'd4});
		send_byte(8'h05);
		send_byte({TYPE_PITCH_BEND, 4'd6});
		send_byte(8'h00);
		send_byte({TYPE_SYSTEM, 4'd2});     // system common drops the half message
		send_byte(8'h50);
		drain_pipeline();
	endtask

	task automatic test_random_stream(input int n_bytes, input logic [3:0] drum);
		logic [7:0] last_status;
		int first;
		set_drum_channel(drum);
		last_status = '0;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes)
			send_random_message(last_status);
		drain_pipeline();
	endtask

	task automatic test_no_idle_stretch(input int n_bytes);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		test_random_stream(n_bytes, 4'($urandom_range(15)));
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_output_stall();
		logic [3:0] ch;
		ch = drum_ch + 4'd1;
		rx_hold_req = 150;
		send_byte({TYPE_NOTE_ON, ch});
		for (int i = 0; i < 40; i++) begin
			send_byte(8'($urandom_range(127)));
			send_byte(8'($urandom_range(127, 1)));
		end
		drain_pipeline();
	endtask

	initial begin : rx_driver
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin : result_checker
		midi_event_t want;
		midi_event_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tdata[1:0];
			got.channel = m_tdata[5:2];
			got.note = m_tdata[12:6];
			got.velocity = m_tdata[19:13];
			got.program_res = m_tdata[26:20];
			if (expected_events.size() == 0) begin
				note_mismatch("event with nothing pending", '0, got, m_tdata[31:27]);
			end else begin
				want = expected_events.pop_front();
				if (want !== got || m_tdata[31:27] !== 5'd0)
					note_mismatch("event mismatch", want, got, m_tdata[31:27]);
				else
					kind_seen[got.kind]++;
				events_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycles,
				expected_events.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold_req = 0;
		reset_parser_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_note_events();
		test_program_table();
		test_drum_notes();
		test_all_off_controls();
		test_silent_messages();
		test_random_stream(200, 4'd0);
		test_random_stream(200, 4'd15);
		test_no_idle_stretch(150);
		test_output_stall();
		test_random_stream(300, DRUM_CHANNEL_RESET);
		drain_pipeline();

		$display("%0d midi bytes in, %0d events checked: note-on %0d, note-off %0d, drum %0d, all-off %0d",
			bytes_sent, events_checked, kind_seen[EV_NOTE_ON], kind_seen[EV_NOTE_OFF],
			kind_seen[EV_DRUM_ON], kind_seen[EV_ALL_OFF]);
		$display("drum channel at 9, 0, 15 and one random value, one long output stall, %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
